// File: src/bge_pkg.sv
// Shared types and constants for the button gesture and encoder event block.
`default_nettype none

package bge_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned PosW  = 16;
  localparam int unsigned RegIdxW = 2;

  localparam logic [CfgW-1:0] MinPressReset    = 16'd50;
  localparam logic [CfgW-1:0] LongPressReset   = 16'd1000;
  localparam logic [CfgW-1:0] DoubleClickReset = 16'd400;

  typedef enum logic [RegIdxW-1:0] {
    REG_MIN_PRESS    = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_DOUBLE_CLICK = 2'd2
  } bge_reg_t;

  typedef struct packed {
    logic [CfgW-1:0] min_press_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_click_ms;
  } bge_cfg_t;

  typedef struct packed {
    logic                   button_level;
    logic [TimeW-1:0]       now_ms;
    logic                   encoder_changed;
    logic signed [PosW-1:0] encoder_position;
  } bge_poll_t;

  typedef struct packed {
    logic press_event;
    logic click_event;
    logic double_click_event;
    logic long_press_event;
    logic cw_event;
    logic ccw_event;
    logic held_cw_event;
    logic held_ccw_event;
    logic button_held;
  } bge_event_t;

endpackage

`default_nettype wire

// File: src/bge_if.sv
// Handshake channel interfaces: poll items in, event items out, register writes.
`default_nettype none

interface bge_poll_if;
  logic                            valid;
  logic                            ready;
  logic                            button_level;
  logic [bge_pkg::TimeW-1:0]       now_ms;
  logic                            encoder_changed;
  logic signed [bge_pkg::PosW-1:0] encoder_position;

  modport source (output valid, output button_level, output now_ms,
                  output encoder_changed, output encoder_position, input ready);
  modport sink (input valid, input button_level, input now_ms,
                input encoder_changed, input encoder_position, output ready);
endinterface

interface bge_event_if;
  logic valid;
  logic ready;
  logic press_event;
  logic click_event;
  logic double_click_event;
  logic long_press_event;
  logic cw_event;
  logic ccw_event;
  logic held_cw_event;
  logic held_ccw_event;
  logic button_held;

  modport source (output valid, output press_event, output click_event,
                  output double_click_event, output long_press_event,
                  output cw_event, output ccw_event, output held_cw_event,
                  output held_ccw_event, output button_held, input ready);
  modport sink (input valid, input press_event, input click_event,
                input double_click_event, input long_press_event,
                input cw_event, input ccw_event, input held_cw_event,
                input held_ccw_event, input button_held, output ready);
endinterface

interface bge_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bge_pkg::RegIdxW-1:0] index;
  logic [bge_pkg::CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/button_gesture_encoder_events_core.sv
// Top level of the button gesture and encoder event block.
//
// Usage: each item on the poll channel is one sample of the button level, a
// millisecond timestamp and an optional new encoder position. For every poll
// item exactly one event item leaves on the events channel, carrying press,
// click, double-click, long-press and encoder direction pulses plus the held
// state after that poll.
// An accepted item is captured in the input register, then the event logic
// feeds the output register, which presents the event item. Throughput is one
// item per cycle while the receiver is ready, set by the single pass of the
// event logic between those two registers.
// When the receiver stalls, the output register holds its item and the input
// register holds the next; poll ready drops only once both are full.
// The cfg channel writes the three timing registers and is always ready;
// index 3 is ignored. Writes are expected only while the block is idle.
// Reset (rst, synchronous) empties both registers, clears all gesture and
// encoder state and restores the timing registers to 50, 1000 and 400 ms.
`default_nettype none

module button_gesture_encoder_events_core (
  input wire logic     clk,
  input wire logic     rst,
  bge_poll_if.sink     poll,
  bge_event_if.source  events,
  bge_cfg_if.sink      cfg
);
  import bge_pkg::*;

  bge_cfg_t   regs;
  bge_poll_t  poll_q;
  bge_event_t result;
  bge_event_t result_q;
  logic       poll_valid;
  logic       out_valid;
  logic       advance;

  assign advance    = poll_valid && (!out_valid || events.ready);
  assign poll.ready = !poll_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (poll.ready) begin
      poll_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      poll_q.button_level     <= poll.button_level;
      poll_q.now_ms           <= poll.now_ms;
      poll_q.encoder_changed  <= poll.encoder_changed;
      poll_q.encoder_position <= poll.encoder_position;
    end
  end

  bge_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bge_event_core u_event_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .poll    (poll_q),
    .regs    (regs),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign events.valid              = out_valid;
  assign events.press_event        = result_q.press_event;
  assign events.click_event        = result_q.click_event;
  assign events.double_click_event = result_q.double_click_event;
  assign events.long_press_event   = result_q.long_press_event;
  assign events.cw_event           = result_q.cw_event;
  assign events.ccw_event          = result_q.ccw_event;
  assign events.held_cw_event      = result_q.held_cw_event;
  assign events.held_ccw_event     = result_q.held_ccw_event;
  assign events.button_held        = result_q.button_held;

endmodule

`default_nettype wire

// File: src/bge_cfg_regs.sv
// Configuration register file for the press, long-press and double-click times.
`default_nettype none

module bge_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  bge_cfg_if.sink          cfg,
  output bge_pkg::bge_cfg_t regs
);
  import bge_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_press_ms    <= MinPressReset;
      regs.long_press_ms   <= LongPressReset;
      regs.double_click_ms <= DoubleClickReset;
    end else if (cfg.valid) begin
      unique case (bge_reg_t'(cfg.index))
        REG_MIN_PRESS:    regs.min_press_ms    <= cfg.data;
        REG_LONG_PRESS:   regs.long_press_ms   <= cfg.data;
        REG_DOUBLE_CLICK: regs.double_click_ms <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bge_event_core.sv
// Gesture and encoder state with the event logic for one registered poll item.
`default_nettype none

module bge_event_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire bge_pkg::bge_poll_t  poll,
  input  wire bge_pkg::bge_cfg_t   regs,
  output bge_pkg::bge_event_t      result
);
  import bge_pkg::*;

  // The held flag always equals the previous button level, so one register serves both.
  logic                   held_flag;
  logic                   long_seen;
  logic [TimeW-1:0]       press_stamp;
  logic [TimeW-1:0]       click_stamp;
  logic signed [PosW-1:0] prior_position;

  logic                   held_flag_next;
  logic                   long_seen_next;
  logic [TimeW-1:0]       held_time;
  logic [TimeW-1:0]       gap;
  logic [TimeW-1:0]       min_ext;
  logic [TimeW-1:0]       long_ext;
  logic [TimeW-1:0]       dbl_ext;
  logic                   rise;
  logic                   fall;
  logic                   click_ok;
  logic                   long_hit;
  logic                   moved_up;
  logic                   moved_down;

  always_comb begin
    min_ext   = {{(TimeW-CfgW){1'b0}}, regs.min_press_ms};
    long_ext  = {{(TimeW-CfgW){1'b0}}, regs.long_press_ms};
    dbl_ext   = {{(TimeW-CfgW){1'b0}}, regs.double_click_ms};
    held_time = poll.now_ms - press_stamp;
    gap       = poll.now_ms - click_stamp;
    rise      = poll.button_level && !held_flag;
    fall      = !poll.button_level && held_flag;
    click_ok  = fall && !long_seen && (held_time >= min_ext) && (held_time < long_ext);
    long_hit  = poll.button_level && held_flag && !long_seen && (held_time >= long_ext);

    held_flag_next = poll.button_level;
    long_seen_next = (rise || fall) ? 1'b0 : (long_seen || long_hit);

    moved_up   = poll.encoder_changed && (poll.encoder_position > prior_position);
    moved_down = poll.encoder_changed && (poll.encoder_position < prior_position);

    result.press_event        = rise;
    result.click_event        = click_ok && (gap > dbl_ext);
    result.double_click_event = click_ok && (gap <= dbl_ext);
    result.long_press_event   = long_hit;
    result.cw_event           = moved_up && !held_flag_next;
    result.ccw_event          = moved_down && !held_flag_next;
    result.held_cw_event      = moved_up && held_flag_next;
    result.held_ccw_event     = moved_down && held_flag_next;
    result.button_held        = held_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag      <= 1'b0;
      long_seen      <= 1'b0;
      press_stamp    <= '0;
      click_stamp    <= '0;
      prior_position <= '0;
    end else if (advance) begin
      held_flag <= held_flag_next;
      long_seen <= long_seen_next;
      if (rise) begin
        press_stamp <= poll.now_ms;
      end
      if (click_ok) begin
        click_stamp <= poll.now_ms;
      end
      if (poll.encoder_changed) begin
        prior_position <= poll.encoder_position;
      end
    end
  end

endmodule

`default_nettype wire

// File: sim/bge_event_checker.sv
// Checker that predicts the event item for every accepted poll and compares it with the block.
`default_nettype none

module bge_event_checker (
  input  wire logic clk,
  input  wire logic rst,
  bge_poll_if       poll,
  bge_event_if      events,
  bge_cfg_if        cfg,
  output int        mismatches,
  output int        outstanding,
  output int        checked
);
  import bge_pkg::*;

  logic [CfgW-1:0]        min_ms;
  logic [CfgW-1:0]        long_ms;
  logic [CfgW-1:0]        dbl_ms;
  logic                   level_q;
  logic                   held_q;
  logic                   long_q;
  logic [TimeW-1:0]       press_ms;
  logic [TimeW-1:0]       click_ms;
  logic signed [PosW-1:0] pos_q;

  bge_event_t pending_events[$];

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch at %0t: %s", $time, msg);
  endtask

  task automatic note_field(input string what, input logic want, input logic got);
    if (got !== want)
      flag($sformatf("item %0d field %s expected %b, got %b", checked, what, want, got));
  endtask

  // Advances the gesture state by one poll and returns the event item it causes.
  function automatic bge_event_t gesture_outcome(input bge_poll_t p);
    bge_event_t       e;
    logic [TimeW-1:0] held_ms;
    logic [TimeW-1:0] gap_ms;
    e = '0;
    held_ms = p.now_ms - press_ms;
    if (p.button_level && !level_q) begin
      held_q = 1'b1;
      press_ms = p.now_ms;
      long_q = 1'b0;
      e.press_event = 1'b1;
    end else if (!p.button_level && level_q) begin
      held_q = 1'b0;
      if (long_q) begin
        long_q = 1'b0;
      end else if (held_ms >= min_ms && held_ms < long_ms) begin
        gap_ms = p.now_ms - click_ms;
        if (gap_ms <= dbl_ms) e.double_click_event = 1'b1;
        else e.click_event = 1'b1;
        click_ms = p.now_ms;
      end
    end else if (p.button_level && !long_q && held_ms >= long_ms) begin
      long_q = 1'b1;
      e.long_press_event = 1'b1;
    end
    level_q = p.button_level;

    // The direction pulse follows the held state left by the button above.
    if (p.encoder_changed) begin
      if ($signed(p.encoder_position) > pos_q) begin
        if (held_q) e.held_cw_event = 1'b1;
        else e.cw_event = 1'b1;
      end else if ($signed(p.encoder_position) < pos_q) begin
        if (held_q) e.held_ccw_event = 1'b1;
        else e.ccw_event = 1'b1;
      end
      pos_q = p.encoder_position;
    end
    e.button_held = held_q;
    return e;
  endfunction

  always @(posedge clk) begin : monitor
    bge_poll_t  p;
    bge_event_t want;
    if (rst) begin
      min_ms = MinPressReset;
      long_ms = LongPressReset;
      dbl_ms = DoubleClickReset;
      level_q = 1'b0;
      held_q = 1'b0;
      long_q = 1'b0;
      press_ms = '0;
      click_ms = '0;
      pos_q = '0;
      pending_events.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MIN_PRESS:    min_ms = cfg.data;
          REG_LONG_PRESS:   long_ms = cfg.data;
          REG_DOUBLE_CLICK: dbl_ms = cfg.data;
          default: ;
        endcase
      end
      if (poll.valid && poll.ready) begin
        p.button_level = poll.button_level;
        p.now_ms = poll.now_ms;
        p.encoder_changed = poll.encoder_changed;
        p.encoder_position = poll.encoder_position;
        pending_events.push_back(gesture_outcome(p));
      end
      if (events.valid && events.ready) begin
        if (pending_events.size() == 0) begin
          flag("event item arrived with nothing expected");
        end else begin
          want = pending_events.pop_front();
          note_field("press_event", want.press_event, events.press_event);
          note_field("click_event", want.click_event, events.click_event);
          note_field("double_click_event", want.double_click_event,
                     events.double_click_event);
          note_field("long_press_event", want.long_press_event, events.long_press_event);
          note_field("cw_event", want.cw_event, events.cw_event);
          note_field("ccw_event", want.ccw_event, events.ccw_event);
          note_field("held_cw_event", want.held_cw_event, events.held_cw_event);
          note_field("held_ccw_event", want.held_ccw_event, events.held_ccw_event);
          note_field("button_held", want.button_held, events.button_held);
        end
        checked++;
      end
    end
    outstanding <= pending_events.size();
  end

endmodule

`default_nettype wire

// File: sim/tb_button_gesture_encoder_events_core.sv
// Testbench top: drives polls, timing writes and receiver stalls, and gives the verdict.
`default_nettype none

module tb_button_gesture_encoder_events_core;
  import bge_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int HoldOff     = 64;
  localparam int DrainCycles = 8;
  localparam logic [RegIdxW-1:0] RegSpare = 2'd3;

  logic clk;
  logic rst;

  bge_poll_if  poll();
  bge_event_if events();
  bge_cfg_if   cfg();

  int mismatches;
  int outstanding;
  int checked;

  int                     polls_sent = 0;
  int                     writes_sent = 0;
  int                     idle_cycles;
  bit                     calm = 1'b0;
  bit                     hold_req = 1'b0;
  bit                     tx_idle = 1'b1;
  logic [TimeW-1:0]       clock_ms;
  logic signed [PosW-1:0] enc_pos;
  logic [CfgW-1:0]        cur_min;
  logic [CfgW-1:0]        cur_long;
  logic [CfgW-1:0]        cur_dbl;

  button_gesture_encoder_events_core u_top (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll),
    .events (events),
    .cfg    (cfg)
  );

  bge_event_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .poll        (poll),
    .events      (events),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one poll item, sometimes after a short gap, and returns once it is taken.
  task automatic send_poll(input logic lvl, input logic [TimeW-1:0] t, input logic chg,
                           input logic signed [PosW-1:0] pos);
    if (!calm && tx_idle && $urandom_range(0, 3) == 0) begin
      poll.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    poll.valid <= 1'b1;
    poll.button_level <= lvl;
    poll.now_ms <= t;
    poll.encoder_changed <= chg;
    poll.encoder_position <= pos;
    do @(posedge clk); while (!poll.ready);
    polls_sent++;
    if (polls_sent % 32 == 0) tx_idle = 1'($urandom_range(0, 1));
  endtask

  // A poll at the given level and time with a randomly chosen encoder move.
  task automatic poll_at(input logic lvl, input logic [TimeW-1:0] t);
    logic                   chg;
    logic signed [PosW-1:0] pos;
    case ($urandom_range(0, 5))
      0, 1: begin chg = 1'b0; pos = PosW'($urandom); end
      2: begin chg = 1'b1; pos = enc_pos; end
      3: begin chg = 1'b1; pos = enc_pos + PosW'(int'($urandom_range(0, 6)) - 3); end
      4: begin chg = 1'b1; pos = PosW'($urandom); end
      default: begin chg = 1'b1; pos = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000; end
    endcase
    if (chg) enc_pos = pos;
    send_poll(lvl, t, chg, pos);
  endtask

  // One press with a few polls while held, then the release, shaped around the timing.
  task automatic press_gesture();
    logic [TimeW-1:0] hold_ms;
    logic [TimeW-1:0] t0;
    int               k;
    case ($urandom_range(0, 4))
      0: hold_ms = (cur_min == 0) ? '0 : $urandom_range(0, cur_min - 1);
      1, 2: hold_ms = (cur_min < cur_long) ? $urandom_range(cur_min, cur_long - 1) : cur_min;
      3: hold_ms = cur_long + $urandom_range(0, 300);
      default: hold_ms = $urandom_range(0, 1) ? TimeW'(cur_min) : TimeW'(cur_long) - 1;
    endcase
    t0 = clock_ms;
    poll_at(1'b1, t0);
    k = $urandom_range(0, 3);
    for (int j = 1; j <= k; j++) poll_at(1'b1, t0 + hold_ms * j / (k + 1));
    if (hold_ms >= cur_long && $urandom_range(0, 1)) begin
      poll_at(1'b1, t0 + cur_long);
      poll_at(1'b1, t0 + cur_long + 1);
    end
    poll_at(1'b0, t0 + hold_ms);
    // Next press often lands close enough for a double click.
    clock_ms = t0 + hold_ms + ($urandom_range(0, 1) ? $urandom_range(1, cur_dbl / 2 + 1)
                                                   : $urandom_range(cur_dbl, cur_dbl + 3000));
  endtask

  task automatic run_phase(input int n);
    int phase_end;
    phase_end = polls_sent + n;
    while (polls_sent < phase_end) begin
      case ($urandom_range(0, 9))
        0: poll_at(1'($urandom_range(0, 1)), $urandom);
        1: begin
          clock_ms = clock_ms + $urandom_range(1, 500);
          poll_at(1'b0, clock_ms);
        end
        default: press_gesture();
      endcase
    end
  endtask

  // Waits until every expected event item has come back.
  task automatic drain();
    poll.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    writes_sent++;
  endtask

  task automatic set_timing(input logic [CfgW-1:0] min_v, input logic [CfgW-1:0] long_v,
                            input logic [CfgW-1:0] dbl_v, input bit spare);
    if (spare) write_reg(RegSpare, CfgW'($urandom));
    write_reg(REG_MIN_PRESS, min_v);
    write_reg(REG_LONG_PRESS, long_v);
    write_reg(REG_DOUBLE_CLICK, dbl_v);
    cfg.valid <= 1'b0;
    cur_min = min_v;
    cur_long = long_v;
    cur_dbl = dbl_v;
  endtask

  // Edge cases at the reset timing of 50, 1000 and 400 ms.
  task automatic directed_polls();
    send_poll(1'b0, 32'd0, 1'b1, 16'sd0);       // repeated position gives no pulse
    send_poll(1'b1, 32'd100, 1'b1, 16'sd5);     // press with a held clockwise move
    send_poll(1'b0, 32'd150, 1'b0, -16'sd7);    // exact minimum, first click near time zero
    send_poll(1'b1, 32'd2000, 1'b0, 16'sd0);
    send_poll(1'b0, 32'd2999, 1'b1, 16'sd5);    // one below the long-press time
    send_poll(1'b1, 32'd5000, 1'b0, 16'sd0);
    send_poll(1'b1, 32'd5999, 1'b0, 16'sd0);
    send_poll(1'b1, 32'd6000, 1'b1, 16'sh7FFF); // long press reached exactly
    send_poll(1'b1, 32'd6500, 1'b1, 16'sh8000); // no second long press
    send_poll(1'b0, 32'd7000, 1'b0, 16'sd0);    // release after long press gives no click
    send_poll(1'b1, 32'd8000, 1'b0, 16'sd0);
    send_poll(1'b0, 32'd8049, 1'b1, 16'sh7FFF); // too short to count
    send_poll(1'b0, 32'd8100, 1'b1, 16'sh8000);
    send_poll(1'b0, 32'd8200, 1'b1, -16'sd1);
    send_poll(1'b1, 32'hFFFF_FFC0, 1'b0, -16'sd1);
    send_poll(1'b0, 32'h0000_0010, 1'b0, 16'sd0); // press spans the timestamp wrap
    send_poll(1'b1, 32'h0000_0100, 1'b0, 16'sd0);
    send_poll(1'b0, 32'h0000_013C, 1'b0, 16'sd0); // double click after the wrap
    send_poll(1'b1, 32'hFFFF_FFFF, 1'b1, -16'sd1);
    send_poll(1'b0, 32'd999, 1'b0, 16'sd0);       // held exactly the long-press time
    clock_ms = 32'd20000;
  endtask

  initial begin : receiver
    forever begin
      if (hold_req) begin
        events.ready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        events.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        events.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        events.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((poll.valid && poll.ready) || (events.valid && events.ready) ||
          (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    rst <= 1'b1;
    poll.valid <= 1'b0;
    poll.button_level <= 1'b0;
    poll.now_ms <= '0;
    poll.encoder_changed <= 1'b0;
    poll.encoder_position <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    clock_ms = '0;
    enc_pos = '0;
    cur_min = MinPressReset;
    cur_long = LongPressReset;
    cur_dbl = DoubleClickReset;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    directed_polls();
    run_phase(120);

    drain();
    set_timing('0, '0, '0, 1'b0);
    run_phase(100);

    drain();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    hold_req = 1'b1;
    run_phase(100);

    drain();
    set_timing('0, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase(100);

    drain();
    set_timing(CfgW'($urandom_range(0, 100)), CfgW'($urandom_range(200, 2000)),
               CfgW'($urandom_range(0, 800)), 1'b1);
    clock_ms = 32'hFFFF_F000;
    hold_req = 1'b1;
    run_phase(140);

    // The last stretch runs with no idling on either side.
    drain();
    set_timing(MinPressReset, LongPressReset, DoubleClickReset, 1'b0);
    calm = 1'b1;
    run_phase(120);

    drain();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d polls and %0d register writes across six timing settings.",
             polls_sent, writes_sent);
    $display("Checked %0d event items, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/bge_pkg.sv
src/bge_if.sv
src/bge_cfg_regs.sv
src/bge_event_core.sv
src/button_gesture_encoder_events_core.sv
sim/bge_event_checker.sv
sim/tb_button_gesture_encoder_events_core.sv
